@@ rtl/jetv_pkg.sv @@
// jetv_pkg: types and constants for the json escaped text validator
// transaction structs, scan mode enum, status and register codes
// no dependencies
`default_nettype none

package jetv_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       last_item;
  } in_t;

  typedef struct packed {
    logic [31:0] text_length;
    logic        has_escape;
    logic        has_multibyte;
    logic [3:0]  status;
    logic [31:0] error_offset;
  } out_t;

  typedef enum logic [2:0] {
    M_TEXT,
    M_ESC,
    M_HEX1,
    M_BS2,
    M_U2,
    M_HEX2,
    M_CONT,
    M_DONE
  } mode_t;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_INCOMPLETE  = 4'd1;
  localparam logic [3:0] ST_BAD_ESCAPE  = 4'd2;
  localparam logic [3:0] ST_BAD_HEX     = 4'd3;
  localparam logic [3:0] ST_NO_LOW      = 4'd4;
  localparam logic [3:0] ST_BAD_LOW     = 4'd5;
  localparam logic [3:0] ST_LONE_LOW    = 4'd6;
  localparam logic [3:0] ST_BAD_UTF8    = 4'd7;
  localparam logic [3:0] ST_OVERFLOW    = 4'd8;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPES_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH      = 2'd1;

  // allowed range of the next utf-8 continuation byte
  localparam logic [2:0] RNG_FULL = 3'd0;
  localparam logic [2:0] RNG_E0   = 3'd1;
  localparam logic [2:0] RNG_ED   = 3'd2;
  localparam logic [2:0] RNG_F0   = 3'd3;
  localparam logic [2:0] RNG_F4   = 3'd4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

endpackage

`default_nettype wire

@@ rtl/json_escaped_text_validator.sv @@
// json_escaped_text_validator: checks escapes and utf-8 of a byte stream
// at most one byte per transaction, one report per text; uses jetv_pkg
//
//  channel | ports                          | direction | content
//  in      | in_valid/in_ready/in_data      | input     | byte, present flag, last flag
//  out     | out_valid/out_ready/out_data   | output    | length, flags, status, offset
//  cfg     | cfg_valid/cfg_ready/cfg_index  | input     | escapes_enabled, max_length
//          | cfg_data                       |           |
//
// one byte per cycle sustained while in_ready stays high
// input register feeds a single pass of scan logic into the report register
// in_ready drops only when a last transaction waits on a full report register
// synchronous active-low reset; cfg_ready is always high
`default_nettype none

module json_escaped_text_validator #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  jetv_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output jetv_pkg::out_t                    out_data,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [jetv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [31:0]                       cfg_data
);
  import jetv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // configuration
  logic                    esc_en_r;
  logic [31:0]             max_len_r;

  // input stage
  logic                    in_valid_r;
  in_t                     in_r;
  logic                    adv;

  // scan state
  mode_t                   mode_r, mode_s;
  logic [1:0]              hex_cnt_r, hex_cnt_s;
  logic [15:0]             hex_acc_r, hex_acc_s;
  logic [1:0]              cont_left_r, cont_left_s;
  logic [2:0]              cont_rng_r, cont_rng_s;
  logic [LENGTH_BITS-1:0]  cnt_r, cnt_s;
  logic                    esc_seen_r, esc_seen_s;
  logic                    mb_seen_r, mb_seen_s;
  logic [3:0]              err_r, err_s, err_e;
  logic [LENGTH_BITS-1:0]  err_off_r, err_off_s, err_off_e;
  logic [LENGTH_BITS-1:0]  anchor_r, anchor_s;
  logic [LENGTH_BITS-1:0]  bh_off_r, bh_off_s;
  logic                    bh_pend_r, bh_pend_s;

  // output stage
  logic                    out_valid_r;
  out_t                    out_r;
  out_t                    res;

  function automatic logic [4:0] hex_nib(input logic [7:0] b);
    logic [4:0] r;
    r = {1'b1, 4'hF};
    if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [LENGTH_BITS-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return (|e[63:32]) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign adv       = in_valid_r && (!in_r.last_item || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r  <= 1'b1;
      max_len_r <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ESCAPES_ENABLED: esc_en_r  <= cfg_data[0];
        CFG_MAX_LENGTH:      max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte step: next state from one byte
  always_comb begin
    logic [7:0]             b;
    logic [LENGTH_BITS-1:0] nxt;
    logic [4:0]             hn;
    logic                   hex_done;
    logic                   fail_en;
    logic [3:0]             fail_code;
    logic [LENGTH_BITS-1:0] fail_off;
    logic [7:0]             lo, hi;

    b         = in_r.text_byte;
    nxt       = (cnt_r == LEN_MAX) ? cnt_r : cnt_r + 1'b1;
    hn        = hex_nib(b);
    hex_done  = 1'b0;
    fail_en   = 1'b0;
    fail_code = ST_OK;
    fail_off  = '0;
    lo        = 8'h80;
    hi        = 8'hBF;

    mode_s      = mode_r;
    hex_cnt_s   = hex_cnt_r;
    hex_acc_s   = hex_acc_r;
    cont_left_s = cont_left_r;
    cont_rng_s  = cont_rng_r;
    cnt_s       = cnt_r;
    esc_seen_s  = esc_seen_r;
    mb_seen_s   = mb_seen_r;
    err_s       = err_r;
    err_off_s   = err_off_r;
    anchor_s    = anchor_r;
    bh_off_s    = bh_off_r;
    bh_pend_s   = bh_pend_r;

    if (in_r.byte_present) begin
      cnt_s = nxt;
      if (mode_r == M_HEX1 || mode_r == M_HEX2) begin
        if (hn[4] && !bh_pend_r) begin
          bh_pend_s = 1'b1;
          bh_off_s  = nxt;
        end
        hex_acc_s = {hex_acc_r[11:0], hn[3:0]};
        if (hex_cnt_r == 2'd3) hex_done = 1'b1;
        else hex_cnt_s = hex_cnt_r + 2'd1;
      end
      unique case (mode_r)
        M_TEXT: begin
          if (esc_en_r && b == CH_BACKSLASH) begin
            esc_seen_s = 1'b1;
            mode_s     = M_ESC;
          end else if (b[7]) begin
            mb_seen_s = 1'b1;
            mode_s    = M_CONT;
            cont_rng_s = RNG_FULL;
            case (b) inside
              [8'hC2:8'hDF]: cont_left_s = 2'd1;
              8'hE0: begin cont_left_s = 2'd2; cont_rng_s = RNG_E0; end
              8'hED: begin cont_left_s = 2'd2; cont_rng_s = RNG_ED; end
              [8'hE1:8'hEF]: cont_left_s = 2'd2;
              8'hF0: begin cont_left_s = 2'd3; cont_rng_s = RNG_F0; end
              [8'hF1:8'hF3]: cont_left_s = 2'd3;
              8'hF4: begin cont_left_s = 2'd3; cont_rng_s = RNG_F4; end
              default: begin
                cont_rng_s = cont_rng_r;
                fail_en    = 1'b1;
                fail_code  = ST_BAD_UTF8;
                fail_off   = cnt_r;
              end
            endcase
          end
        end
        M_ESC: begin
          case (b) inside
            CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
              mode_s = M_TEXT;
            CH_U: begin
              hex_cnt_s = 2'd0;
              hex_acc_s = 16'h0;
              bh_pend_s = 1'b0;
              anchor_s  = nxt;
              mode_s    = M_HEX1;
            end
            default: begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_ESCAPE;
              fail_off  = nxt;
            end
          endcase
        end
        M_HEX1: begin
          if (hex_done) begin
            if (bh_pend_s) begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_HEX;
              fail_off  = bh_off_s;
            end else if (hex_acc_s >= 16'hD800 && hex_acc_s <= 16'hDBFF) begin
              anchor_s = nxt;
              mode_s   = M_BS2;
            end else if (hex_acc_s >= 16'hDC00 && hex_acc_s <= 16'hDFFF) begin
              fail_en   = 1'b1;
              fail_code = ST_LONE_LOW;
              fail_off  = nxt;
            end else begin
              if (hex_acc_s >= 16'h0080) mb_seen_s = 1'b1;
              mode_s = M_TEXT;
            end
          end
        end
        M_BS2: begin
          if (b == CH_BACKSLASH) begin
            mode_s = M_U2;
          end else begin
            fail_en   = 1'b1;
            fail_code = ST_NO_LOW;
            fail_off  = anchor_r;
          end
        end
        M_U2: begin
          if (b == CH_U) begin
            hex_cnt_s = 2'd0;
            hex_acc_s = 16'h0;
            bh_pend_s = 1'b0;
            mode_s    = M_HEX2;
          end else begin
            fail_en   = 1'b1;
            fail_code = ST_NO_LOW;
            fail_off  = anchor_r;
          end
        end
        M_HEX2: begin
          if (hex_done) begin
            if (bh_pend_s) begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_HEX;
              fail_off  = bh_off_s;
            end else if (hex_acc_s < 16'hDC00 || hex_acc_s > 16'hDFFF) begin
              fail_en   = 1'b1;
              fail_code = ST_BAD_LOW;
              fail_off  = anchor_r;
            end else begin
              mb_seen_s = 1'b1;
              mode_s    = M_TEXT;
            end
          end
        end
        M_CONT: begin
          case (cont_rng_r)
            RNG_E0:  lo = 8'hA0;
            RNG_ED:  hi = 8'h9F;
            RNG_F0:  lo = 8'h90;
            RNG_F4:  hi = 8'h8F;
            default: ;
          endcase
          if (b < lo || b > hi) begin
            fail_en   = 1'b1;
            fail_code = ST_BAD_UTF8;
            fail_off  = cnt_r;
          end else begin
            cont_rng_s  = RNG_FULL;
            cont_left_s = cont_left_r - 2'd1;
            if (cont_left_r == 2'd1) mode_s = M_TEXT;
          end
        end
        M_DONE: ;
        default: ;
      endcase
      if (fail_en) begin
        if (err_r == ST_OK) begin
          err_s     = fail_code;
          err_off_s = fail_off;
        end
        mode_s = M_DONE;
      end
    end
  end

  // end of text: pending-mode errors and report
  always_comb begin
    logic [63:0] cnt64;

    cnt64     = 64'(cnt_s);
    err_e     = err_s;
    err_off_e = err_off_s;
    unique case (mode_s)
      M_ESC:  begin err_e = ST_INCOMPLETE; err_off_e = cnt_s;    end
      M_HEX1: begin err_e = ST_INCOMPLETE; err_off_e = anchor_s; end
      M_BS2, M_U2, M_HEX2: begin
        err_e     = ST_NO_LOW;
        err_off_e = anchor_s;
      end
      M_CONT: begin err_e = ST_BAD_UTF8; err_off_e = cnt_s; end
      default: ;
    endcase
    if (err_s != ST_OK) begin
      err_e     = err_s;
      err_off_e = err_off_s;
    end

    res.text_length   = sat32(cnt_s);
    res.has_escape    = esc_seen_s;
    res.has_multibyte = mb_seen_s;
    if (err_e != ST_OK) begin
      res.status       = err_e;
      res.error_offset = sat32(err_off_e);
    end else if (cnt64 > {32'h0, max_len_r}) begin
      res.status       = ST_OVERFLOW;
      res.error_offset = max_len_r;
    end else begin
      res.status       = ST_OK;
      res.error_offset = 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && in_r.last_item)) begin
      mode_r      <= M_TEXT;
      hex_cnt_r   <= 2'd0;
      hex_acc_r   <= 16'h0;
      cont_left_r <= 2'd0;
      cont_rng_r  <= RNG_FULL;
      cnt_r       <= '0;
      esc_seen_r  <= 1'b0;
      mb_seen_r   <= 1'b0;
      err_r       <= ST_OK;
      err_off_r   <= '0;
      anchor_r    <= '0;
      bh_off_r    <= '0;
      bh_pend_r   <= 1'b0;
    end else if (adv) begin
      mode_r      <= mode_s;
      hex_cnt_r   <= hex_cnt_s;
      hex_acc_r   <= hex_acc_s;
      cont_left_r <= cont_left_s;
      cont_rng_r  <= cont_rng_s;
      cnt_r       <= cnt_s;
      esc_seen_r  <= esc_seen_s;
      mb_seen_r   <= mb_seen_s;
      err_r       <= err_s;
      err_off_r   <= err_off_s;
      anchor_r    <= anchor_s;
      bh_off_r    <= bh_off_s;
      bh_pend_r   <= bh_pend_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && in_r.last_item) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_r.last_item) begin
      out_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/jetv_checker.sv @@
// jetv_checker: port-level checks of the json escaped text validator reports
// uses jetv_pkg; bound to json_escaped_text_validator at the end of this file
`default_nettype none

module jetv_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            out_valid,
  input wire            out_ready,
  input jetv_pkg::out_t out_data
);
  import jetv_pkg::*;

  // stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("report changed while stalled");

  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |-> out_data.error_offset == 32'h0)
    else $error("clean report with nonzero offset");

  a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.error_offset <= out_data.text_length)
    else $error("error offset beyond text length");

  a_ovf_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OVERFLOW |->
      out_data.error_offset < out_data.text_length)
    else $error("overflow with length not above limit");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_OVERFLOW)
    else $error("status code out of range");

endmodule

bind json_escaped_text_validator jetv_checker u_jetv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/json_escaped_text_validator_tb.sv @@
`timescale 1ns / 100ps
// json_escaped_text_validator_tb: self-checking bench for the escaped text validator
// a predictor scores each text byte; reports are checked against it in order
// depends on jetv_pkg and json_escaped_text_validator

module json_escaped_text_validator_tb;
  import jetv_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_SHOWN = 10;
  localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B,
                                           CH_F, CH_N, CH_R, CH_T};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit send_noise = 1'b0;
  int error_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  out_t       reports_due[$];
  logic [7:0] text_buf[$];

  // predictor state
  bit          cfg_esc;
  logic [31:0] cfg_maxlen;
  mode_t       sm;
  logic [1:0]  hexn;
  logic [15:0] hacc;
  logic [1:0]  cont_left;
  logic [2:0]  cont_rng;
  logic [31:0] cnt;
  bit          esc_flag;
  bit          mb_flag;
  logic [3:0]  err_code;
  logic [31:0] err_off;
  logic [31:0] anchor;
  logic [31:0] badhex_off;
  bit          badhex;

  json_escaped_text_validator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_text();
    sm = M_TEXT;
    hexn = '0;
    hacc = '0;
    cont_left = '0;
    cont_rng = RNG_FULL;
    cnt = '0;
    esc_flag = 1'b0;
    mb_flag = 1'b0;
    err_code = ST_OK;
    err_off = '0;
    anchor = '0;
    badhex_off = '0;
    badhex = 1'b0;
  endfunction

  function automatic void note_error(logic [3:0] code, logic [31:0] off);
    if (err_code == ST_OK) begin
      err_code = code;
      err_off = off;
    end
    sm = M_DONE;
  endfunction

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void start_hex();
    hexn = '0;
    hacc = '0;
    badhex = 1'b0;
  endfunction

  // returns 1 once the fourth digit position is in
  function automatic bit take_hex(logic [7:0] b, logic [31:0] nxt);
    int h;
    h = hex_nibble(b);
    if (h < 0 && !badhex) begin
      badhex = 1'b1;
      badhex_off = nxt;
    end
    hacc = {hacc[11:0], (h < 0) ? 4'hF : h[3:0]};
    if (hexn == 2'd3) return 1'b1;
    hexn++;
    return 1'b0;
  endfunction

  function automatic void begin_utf8(logic [7:0] b, logic [31:0] pos);
    logic [1:0] left;
    logic [2:0] rng;
    left = 2'd0;
    rng = RNG_FULL;
    if (b inside {[8'hC2:8'hDF]}) left = 2'd1;
    else if (b == 8'hE0) begin
      left = 2'd2;
      rng = RNG_E0;
    end else if (b == 8'hED) begin
      left = 2'd2;
      rng = RNG_ED;
    end else if (b inside {[8'hE1:8'hEF]}) left = 2'd2;
    else if (b == 8'hF0) begin
      left = 2'd3;
      rng = RNG_F0;
    end else if (b inside {[8'hF1:8'hF3]}) left = 2'd3;
    else if (b == 8'hF4) begin
      left = 2'd3;
      rng = RNG_F4;
    end
    if (left == 2'd0) begin
      note_error(ST_BAD_UTF8, pos);
      return;
    end
    cont_left = left;
    cont_rng = rng;
    sm = M_CONT;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    logic [31:0] pos;
    logic [31:0] nxt;
    logic [7:0]  lo;
    logic [7:0]  hi;
    pos = cnt;
    nxt = (cnt == '1) ? cnt : cnt + 32'd1;
    cnt = nxt;
    case (sm)
      M_TEXT: begin
        if (cfg_esc && b == CH_BACKSLASH) begin
          esc_flag = 1'b1;
          sm = M_ESC;
        end else if (b[7]) begin
          mb_flag = 1'b1;
          begin_utf8(b, pos);
        end
      end
      M_ESC: begin
        if (b inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T}) begin
          sm = M_TEXT;
        end else if (b == CH_U) begin
          start_hex();
          anchor = nxt;
          sm = M_HEX1;
        end else begin
          note_error(ST_BAD_ESCAPE, nxt);
        end
      end
      M_HEX1: begin
        if (take_hex(b, nxt)) begin
          if (badhex) note_error(ST_BAD_HEX, badhex_off);
          else if (hacc inside {[16'hD800:16'hDBFF]}) begin
            anchor = nxt;
            sm = M_BS2;
          end else if (hacc inside {[16'hDC00:16'hDFFF]}) begin
            note_error(ST_LONE_LOW, nxt);
          end else begin
            if (hacc >= 16'h0080) mb_flag = 1'b1;
            sm = M_TEXT;
          end
        end
      end
      M_BS2: begin
        if (b == CH_BACKSLASH) sm = M_U2;
        else note_error(ST_NO_LOW, anchor);
      end
      M_U2: begin
        if (b == CH_U) begin
          start_hex();
          sm = M_HEX2;
        end else begin
          note_error(ST_NO_LOW, anchor);
        end
      end
      M_HEX2: begin
        if (take_hex(b, nxt)) begin
          if (badhex) note_error(ST_BAD_HEX, badhex_off);
          else if (!(hacc inside {[16'hDC00:16'hDFFF]})) note_error(ST_BAD_LOW, anchor);
          else begin
            mb_flag = 1'b1;
            sm = M_TEXT;
          end
        end
      end
      M_CONT: begin
        lo = 8'h80;
        hi = 8'hBF;
        case (cont_rng)
          RNG_E0: lo = 8'hA0;
          RNG_ED: hi = 8'h9F;
          RNG_F0: lo = 8'h90;
          RNG_F4: hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) begin
          note_error(ST_BAD_UTF8, pos);
        end else begin
          cont_rng = RNG_FULL;
          cont_left--;
          if (cont_left == 2'd0) sm = M_TEXT;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void validate_item(in_t it);
    out_t rep;
    if (it.byte_present) scan_byte(it.text_byte);
    if (!it.last_item) return;
    case (sm)
      M_ESC: note_error(ST_INCOMPLETE, cnt);
      M_HEX1: note_error(ST_INCOMPLETE, anchor);
      M_BS2, M_U2, M_HEX2: note_error(ST_NO_LOW, anchor);
      M_CONT: note_error(ST_BAD_UTF8, cnt);
      default: ;
    endcase
    rep.text_length = cnt;
    rep.has_escape = esc_flag;
    rep.has_multibyte = mb_flag;
    if (err_code != ST_OK) begin
      rep.status = err_code;
      rep.error_offset = err_off;
    end else if (cnt > cfg_maxlen) begin
      rep.status = ST_OVERFLOW;
      rep.error_offset = cfg_maxlen;
    end else begin
      rep.status = ST_OK;
      rep.error_offset = '0;
    end
    reports_due.push_back(rep);
    clear_text();
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("unexpected report: len %0d status %0d off %0d",
                   out_data.text_length, out_data.status, out_data.error_offset);
      end else begin
        want = reports_due.pop_front();
        if (out_data.text_length !== want.text_length ||
            out_data.has_escape !== want.has_escape ||
            out_data.has_multibyte !== want.has_multibyte ||
            out_data.status !== want.status ||
            out_data.error_offset !== want.error_offset) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("report mismatch: expected len %0d esc %0b mb %0b st %0d off %0d, %s",
                     want.text_length, want.has_escape, want.has_multibyte, want.status,
                     want.error_offset,
                     $sformatf("got len %0d esc %0b mb %0b st %0d off %0d",
                               out_data.text_length, out_data.has_escape,
                               out_data.has_multibyte, out_data.status,
                               out_data.error_offset));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(input in_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    validate_item(it);
  endtask

  task automatic send_text(input bit bare_end);
    in_t it;
    for (int i = 0; i < text_buf.size(); i++) begin
      if (send_noise && $urandom_range(19) == 0) begin
        it.text_byte = 8'($urandom);
        it.byte_present = 1'b0;
        it.last_item = 1'b0;
        send_item(it);
      end
      it.text_byte = text_buf[i];
      it.byte_present = 1'b1;
      it.last_item = !bare_end && (i == text_buf.size() - 1);
      send_item(it);
      items_sent++;
    end
    if (bare_end || text_buf.size() == 0) begin
      it.text_byte = 8'($urandom);
      it.byte_present = 1'b0;
      it.last_item = 1'b1;
      send_item(it);
      items_sent++;
    end
  endtask

  function automatic void load_str(string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic send_str(input string s, input bit bare_end);
    load_str(s);
    send_text(bare_end);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ESCAPES_ENABLED) cfg_esc = val[0];
    else if (idx == CFG_MAX_LENGTH) cfg_maxlen = val;
  endtask

  function automatic logic [31:0] pick_in(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n - 4'd10};
  endfunction

  function automatic void push_u(logic [15:0] v, int digits);
    text_buf.push_back(CH_BACKSLASH);
    text_buf.push_back(CH_U);
    for (int i = 0; i < digits; i++) text_buf.push_back(hex_char(v[15 - 4*i -: 4]));
  endfunction

  function automatic void push_utf8(bit truncate);
    int         len;
    int         keep;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    len = $urandom_range(2, 4);
    lo = 8'h80;
    hi = 8'hBF;
    case (len)
      2: lead = 8'(pick_in(32'hC2, 32'hDF));
      3: lead = 8'(pick_in(32'hE0, 32'hEF));
      default: lead = 8'(pick_in(32'hF0, 32'hF4));
    endcase
    if (lead == 8'hE0) lo = 8'hA0;
    else if (lead == 8'hED) hi = 8'h9F;
    else if (lead == 8'hF0) lo = 8'h90;
    else if (lead == 8'hF4) hi = 8'h8F;
    keep = truncate ? $urandom_range(0, len - 2) : len - 1;
    text_buf.push_back(lead);
    for (int i = 0; i < keep; i++) begin
      text_buf.push_back(8'(pick_in(32'(lo), 32'(hi))));
      lo = 8'h80;
      hi = 8'hBF;
    end
  endfunction

  function automatic void push_good_token();
    logic [7:0]  b;
    logic [15:0] w;
    case ($urandom_range(5))
      1: begin
        text_buf.push_back(CH_BACKSLASH);
        text_buf.push_back(SIMPLE_ESC[$urandom_range(7)]);
      end
      2: begin
        w = $urandom_range(1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        if (w inside {[16'hD800:16'hDFFF]}) w ^= 16'h2000;
        push_u(w, 4);
      end
      3: begin
        push_u(16'(pick_in(32'hD800, 32'hDBFF)), 4);
        push_u(16'(pick_in(32'hDC00, 32'hDFFF)), 4);
      end
      4: push_utf8(1'b0);
      default: begin
        b = 8'($urandom_range(0, 127));
        if (b == CH_BACKSLASH) b = 8'h20;
        text_buf.push_back(b);
      end
    endcase
  endfunction

  // returns 1 when the token leaves the text unfinished, so the text must end
  function automatic bit push_bad_token();
    logic [7:0] b;
    int         k;
    case ($urandom_range(8))
      0: text_buf.push_back(8'($urandom));
      1: begin
        text_buf.push_back(CH_BACKSLASH);
        text_buf.push_back(8'($urandom));
      end
      2: begin
        k = text_buf.size() + 2 + $urandom_range(3);
        push_u(16'($urandom), 4);
        text_buf[k] = 8'($urandom);
      end
      3: push_u(16'(pick_in(32'hDC00, 32'hDFFF)), 4);
      4: begin
        push_u(16'(pick_in(32'hD800, 32'hDBFF)), 4);
        if ($urandom_range(1)) text_buf.push_back(CH_BACKSLASH);
        text_buf.push_back(8'($urandom));
      end
      5: begin
        push_u(16'(pick_in(32'hD800, 32'hDBFF)), 4);
        push_u(16'($urandom), 4);
      end
      6: begin
        push_utf8(1'b1);
        text_buf.push_back(8'($urandom));
      end
      7: begin
        case ($urandom_range(3))
          0: b = 8'(pick_in(32'hC0, 32'hC1));
          1: b = 8'(pick_in(32'hF5, 32'hFF));
          default: b = 8'(pick_in(32'h80, 32'hBF));
        endcase
        text_buf.push_back(b);
      end
      default: begin
        case ($urandom_range(3))
          0: text_buf.push_back(CH_BACKSLASH);
          1: push_u(16'($urandom), $urandom_range(0, 3));
          2: begin
            push_u(16'(pick_in(32'hD800, 32'hDBFF)), 4);
            if ($urandom_range(2) == 0) text_buf.push_back(CH_BACKSLASH);
            else push_u(16'(pick_in(32'hDC00, 32'hDFFF)), $urandom_range(0, 3));
          end
          default: push_utf8(1'b1);
        endcase
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void build_random_text();
    int ntok;
    text_buf.delete();
    ntok = $urandom_range(0, 10);
    for (int i = 0; i < ntok; i++) begin
      if ($urandom_range(99) < 85) push_good_token();
      else if (push_bad_token()) break;
    end
  endfunction

  task automatic random_config();
    logic [31:0] val;
    case ($urandom_range(3))
      0: begin
        val = $urandom;
        val[0] = ($urandom_range(3) != 0);
        write_reg(CFG_ESCAPES_ENABLED, val);
      end
      1: write_reg(CFG_MAX_LENGTH, $urandom_range(0, 30));
      2: write_reg(CFG_MAX_LENGTH, $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF);
      default: write_reg(CFG_MAX_LENGTH, $urandom);
    endcase
  endtask

  task automatic test_plain_extremes();
    send_str("", 1'b1);
    text_buf = '{8'h00, 8'h7F};
    send_text(1'b0);
    text_buf = '{8'hFF};
    send_text(1'b1);
  endtask

  task automatic test_simple_escapes();
    send_str("\\\"\\\\\\/\\b\\f\\n\\r\\t", 1'b1);
  endtask

  task automatic test_unicode_escapes();
    send_str("\\u007F\\u0080", 1'b0);
    send_str("\\uD800\\uDFFF\\udbff\\uDC00", 1'b0);
  endtask

  task automatic test_escape_errors();
    send_str("\\q", 1'b0);
    send_str("\\u0G0z", 1'b0);
    send_str("\\u12", 1'b0);
    send_str("ab\\", 1'b1);
    send_str("\\uDBFFx", 1'b0);
    send_str("\\uD800\\u0041", 1'b0);
    send_str("\\uDC00", 1'b0);
    send_str("\\uD800\\u", 1'b1);
  endtask

  task automatic test_utf8_forms();
    text_buf = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(1'b0);
    text_buf = '{8'hC0, 8'h80};
    send_text(1'b0);
    text_buf = '{8'hE0, 8'h9F};
    send_text(1'b0);
    text_buf = '{8'hED, 8'hA0};
    send_text(1'b0);
    text_buf = '{8'hF4, 8'h90};
    send_text(1'b0);
    text_buf = '{8'h41, 8'hF5};
    send_text(1'b0);
    text_buf = '{8'h80};
    send_text(1'b0);
    text_buf = '{8'hE2, 8'h82};
    send_text(1'b0);
  endtask

  task automatic test_escapes_disabled();
    write_reg(CFG_ESCAPES_ENABLED, 32'd0);
    load_str("\\q\\u");
    text_buf.push_back(8'hC3);
    text_buf.push_back(8'hA9);
    send_text(1'b0);
    send_str("\\uDC00\\", 1'b1);
    write_reg(CFG_ESCAPES_ENABLED, 32'd1);
  endtask

  task automatic test_overflow();
    write_reg(CFG_MAX_LENGTH, 32'd3);
    send_str("abcd", 1'b0);
    send_str("abc", 1'b1);
    write_reg(CFG_MAX_LENGTH, 32'd0);
    send_str("", 1'b1);
    send_str("a", 1'b0);
    send_str("\\q", 1'b0);
    write_reg(CFG_MAX_LENGTH, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int count);
    int goal;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    send_noise = 1'b1;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(9) == 0) random_config();
      build_random_text();
      send_text($urandom_range(3) == 0);
    end
  endtask

  initial begin
    cfg_esc = 1'b1;
    cfg_maxlen = 32'hFFFF_FFFF;
    clear_text();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_extremes();
    test_simple_escapes();
    test_unicode_escapes();
    test_escape_errors();
    test_utf8_forms();
    test_escapes_disabled();
    test_overflow();
    test_random_stream(0, 0, 350);
    test_random_stream(62, 0, 350);
    test_random_stream(0, 62, 350);
    test_random_stream(10, 10, 350);
    settle();
    if (reports_due.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/jetv_pkg.sv
rtl/json_escaped_text_validator.sv
rtl/jetv_checker.sv
tb/json_escaped_text_validator_tb.sv
